FILE: rtl/core/rgbycc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbycc_pkg
// Constants and types for the RGB pair to YCbCr 4:2:2 converter.
// ----------------------------------------------------------------------------
package rgbycc_pkg;

    localparam int unsigned PIX_W  = 8;
    localparam int unsigned COEF_W = 16;
    localparam int unsigned ACC_W  = 24;
    localparam int unsigned FRAC_W = 16;

    // BT.601 studio-range coefficients, unsigned Q0.16
    localparam logic [COEF_W-1:0] COEF_Y_R  = 16'd16843;
    localparam logic [COEF_W-1:0] COEF_Y_G  = 16'd33030;
    localparam logic [COEF_W-1:0] COEF_Y_B  = 16'd6423;
    localparam logic [COEF_W-1:0] COEF_CR_R = 16'd28770;
    localparam logic [COEF_W-1:0] COEF_CR_G = 16'd24117;
    localparam logic [COEF_W-1:0] COEF_CR_B = 16'd4653;
    localparam logic [COEF_W-1:0] COEF_CB_R = 16'd9699;
    localparam logic [COEF_W-1:0] COEF_CB_G = 16'd19071;
    localparam logic [COEF_W-1:0] COEF_CB_B = 16'd28770;

    localparam logic [ACC_W-1:0] OFFS_Y = 24'd16 << FRAC_W;
    localparam logic [ACC_W-1:0] OFFS_C = 24'd128 << FRAC_W;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } t_rgb;

    typedef struct packed {
        logic [PIX_W-1:0] cb;
        logic [PIX_W-1:0] cr;
        logic [PIX_W-1:0] y;
    } t_ycc;

endpackage

FILE: rtl/core/rgb_pair_to_ycbcr422.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_pair_to_ycbcr422
// Converts two adjacent RGB pixels into one BT.601 4:2:2 YCbCr word.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis carries one pixel pair per transfer: R0, G0, B0,
//   R1, G1, B1 from the lowest byte up, with tlast marking the last pair of
//   a frame. Master stream m_axis returns Y0, Cr, Y1, Cb from the lowest
//   byte up, with tlast copied from the input pair.
//   The datapath is two register stages: an input register and a result
//   register, with the per-pixel multiply-accumulate, the chroma average and
//   the clamp as one combinational pass between them.
//   An accepted pair is taken into the input register, then into the result
//   register, which drives m_axis_tvalid.
//   Throughput is one pair per clock while m_axis_tready is high; each
//   stage advances whenever the stage ahead is empty or moving.
//   Bubbles are squeezed out and up to two pairs are held while
//   m_axis_tready is low; s_axis_tready drops only once both stages are full.
//   Synchronous active-low reset empties the pipeline; no output is shown
//   until a new pair has been accepted.
// ----------------------------------------------------------------------------
module rgb_pair_to_ycbcr422 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] red_first, [15:8] green_first, [23:16] blue_first,
    // [31:24] red_second, [39:32] green_second, [47:40] blue_second
    input  logic [47:0] s_axis_tdata,
    input  logic        s_axis_tlast,   // pair_is_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] luma_first, [15:8] chroma_red, [23:16] luma_second,
    // [31:24] chroma_blue
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tlast    // out_is_last
);

    localparam int unsigned PW = rgbycc_pkg::PIX_W;
    localparam int unsigned AW = rgbycc_pkg::ACC_W;
    localparam int unsigned FW = rgbycc_pkg::FRAC_W;

    // stage enables
    logic en_o;
    logic en_a;

    // input register
    logic              r_va;
    rgbycc_pkg::t_rgb  r_pix0;
    rgbycc_pkg::t_rgb  r_pix1;
    logic              r_last_a;

    // result register
    logic              r_vo;
    logic [PW-1:0]     r_y0;
    logic [PW-1:0]     r_y1;
    logic [PW-1:0]     r_cr;
    logic [PW-1:0]     r_cb;
    logic              r_last_o;

    rgbycc_pkg::t_ycc  n_ycc0;
    rgbycc_pkg::t_ycc  n_ycc1;
    logic [PW-1:0]     n_cr;
    logic [PW-1:0]     n_cb;

    assign en_o          = !r_vo || m_axis_tready;
    assign en_a          = !r_va || en_o;
    assign s_axis_tready = en_a;

    function automatic logic [PW-1:0] sat8(input logic [AW-FW-1:0] v);
        logic [PW-1:0] res;
        res = (v > (AW-FW)'(255)) ? PW'(255) : v[PW-1:0];
        return res;
    endfunction

    function automatic rgbycc_pkg::t_ycc convert(input rgbycc_pkg::t_rgb p);
        logic [AW-1:0]    acc_y;
        logic [AW-1:0]    acc_cr;
        logic [AW-1:0]    acc_cb;
        rgbycc_pkg::t_ycc res;
        // positive terms first; the sums never go negative for 8-bit inputs
        acc_y  = rgbycc_pkg::OFFS_Y
               + AW'(rgbycc_pkg::COEF_Y_R) * AW'(p.red)
               + AW'(rgbycc_pkg::COEF_Y_G) * AW'(p.green)
               + AW'(rgbycc_pkg::COEF_Y_B) * AW'(p.blue);
        acc_cr = rgbycc_pkg::OFFS_C
               + AW'(rgbycc_pkg::COEF_CR_R) * AW'(p.red)
               - AW'(rgbycc_pkg::COEF_CR_G) * AW'(p.green)
               - AW'(rgbycc_pkg::COEF_CR_B) * AW'(p.blue);
        acc_cb = rgbycc_pkg::OFFS_C
               + AW'(rgbycc_pkg::COEF_CB_B) * AW'(p.blue)
               - AW'(rgbycc_pkg::COEF_CB_R) * AW'(p.red)
               - AW'(rgbycc_pkg::COEF_CB_G) * AW'(p.green);
        res.y  = sat8(acc_y[AW-1:FW]);
        res.cr = acc_cr[FW+PW-1:FW];
        res.cb = acc_cb[FW+PW-1:FW];
        return res;
    endfunction

    always_comb begin
        logic [PW:0] sum_cr;
        logic [PW:0] sum_cb;
        n_ycc0 = convert(r_pix0);
        n_ycc1 = convert(r_pix1);
        sum_cr = {1'b0, n_ycc0.cr} + {1'b0, n_ycc1.cr};
        sum_cb = {1'b0, n_ycc0.cb} + {1'b0, n_ycc1.cb};
        n_cr   = sat8((AW-FW)'(sum_cr >> 1));
        n_cb   = sat8((AW-FW)'(sum_cb >> 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (en_a) begin
                r_va <= s_axis_tvalid;
            end
            if (en_o) begin
                r_vo <= r_va;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_pix0   <= s_axis_tdata[3*PW-1:0];
            r_pix1   <= s_axis_tdata[6*PW-1:3*PW];
            r_last_a <= s_axis_tlast;
        end
        if (en_o) begin
            r_y0     <= n_ycc0.y;
            r_y1     <= n_ycc1.y;
            r_cr     <= n_cr;
            r_cb     <= n_cb;
            r_last_o <= r_last_a;
        end
    end

    assign m_axis_tvalid = r_vo;
    assign m_axis_tdata  = {r_cb, r_y1, r_cr, r_y0};
    assign m_axis_tlast  = r_last_o;

endmodule

FILE: rtl/core/rgbycc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbycc_checker
// Port-level checks for the RGB pair to YCbCr 4:2:2 converter.
// ----------------------------------------------------------------------------
module rgbycc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output changed");

    // an empty output stage leaves room for a new transfer
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // a moving output lets the whole pipeline advance
    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");

    // studio-range luma stays within 16..235
    a_luma_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:0] >= 8'd16 && m_axis_tdata[7:0] <= 8'd235
            && m_axis_tdata[23:16] >= 8'd16 && m_axis_tdata[23:16] <= 8'd235)
        else $error("luma out of studio range");

    // no stale result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind rgb_pair_to_ycbcr422 rgbycc_checker u_rgbycc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

FILE: tb/sv/ycc422_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycc422_checker
// Watches both streams of the RGB pair to YCbCr 4:2:2 converter. Each pixel
// pair taken on the slave side is converted here in fixed point and queued;
// each word leaving the master side is compared field by field with the
// oldest queued word. Reports the failure count and the number of words
// still outstanding.
// ----------------------------------------------------------------------------
module ycc422_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    // [7:0] red_first, [15:8] green_first, [23:16] blue_first,
    // [31:24] red_second, [39:32] green_second, [47:40] blue_second
    input  logic [47:0] i_s_tdata,
    input  logic        i_s_tlast,  // pair_is_last
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] luma_first, [15:8] chroma_red, [23:16] luma_second,
    // [31:24] chroma_blue
    input  logic [31:0] i_m_tdata,
    input  logic        i_m_tlast,  // out_is_last
    output int          o_fail_count,
    output int          o_pending
);

    // BT.601 studio range, unsigned Q0.16
    localparam logic [31:0] K_Y_R  = 32'd16843;
    localparam logic [31:0] K_Y_G  = 32'd33030;
    localparam logic [31:0] K_Y_B  = 32'd6423;
    localparam logic [31:0] K_CR_R = 32'd28770;
    localparam logic [31:0] K_CR_G = 32'd24117;
    localparam logic [31:0] K_CR_B = 32'd4653;
    localparam logic [31:0] K_CB_R = 32'd9699;
    localparam logic [31:0] K_CB_G = 32'd19071;
    localparam logic [31:0] K_CB_B = 32'd28770;
    localparam logic [31:0] LUMA_BIAS   = 32'd16 << 16;
    localparam logic [31:0] CHROMA_BIAS = 32'd128 << 16;
    localparam int          MAX_REPORTS = 10;

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] chroma_red;
        logic [7:0] luma_second;
        logic [7:0] chroma_blue;
        logic       is_last;
    } t_ycc_word;

    t_ycc_word expected_words[$];

    function automatic logic [31:0] luma_of(logic [31:0] r, logic [31:0] g,
                                            logic [31:0] b);
        return (LUMA_BIAS + K_Y_R * r + K_Y_G * g + K_Y_B * b) >> 16;
    endfunction

    // add the positive term first so nothing wraps below zero
    function automatic logic [31:0] cr_of(logic [31:0] r, logic [31:0] g,
                                          logic [31:0] b);
        return (CHROMA_BIAS + K_CR_R * r - K_CR_G * g - K_CR_B * b) >> 16;
    endfunction

    function automatic logic [31:0] cb_of(logic [31:0] r, logic [31:0] g,
                                          logic [31:0] b);
        return (CHROMA_BIAS + K_CB_B * b - K_CB_R * r - K_CB_G * g) >> 16;
    endfunction

    function automatic logic [7:0] clamp8(logic [31:0] v);
        return (v > 32'd255) ? 8'd255 : v[7:0];
    endfunction

    function automatic t_ycc_word convert_pair(logic [47:0] pix, logic last);
        logic [31:0] r0, g0, b0, r1, g1, b1;
        t_ycc_word   w;
        r0 = {24'd0, pix[7:0]};
        g0 = {24'd0, pix[15:8]};
        b0 = {24'd0, pix[23:16]};
        r1 = {24'd0, pix[31:24]};
        g1 = {24'd0, pix[39:32]};
        b1 = {24'd0, pix[47:40]};
        w.luma_first  = clamp8(luma_of(r0, g0, b0));
        w.luma_second = clamp8(luma_of(r1, g1, b1));
        w.chroma_red  = clamp8((cr_of(r0, g0, b0) + cr_of(r1, g1, b1)) >> 1);
        w.chroma_blue = clamp8((cb_of(r0, g0, b0) + cb_of(r1, g1, b1)) >> 1);
        w.is_last     = last;
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_ycc_word want;
        t_ycc_word got;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.luma_first  = i_m_tdata[7:0];
                got.chroma_red  = i_m_tdata[15:8];
                got.luma_second = i_m_tdata[23:16];
                got.chroma_blue = i_m_tdata[31:24];
                got.is_last     = i_m_tlast;
                if (expected_words.size() == 0) begin
                    if (o_fail_count < MAX_REPORTS)
                        $display("%0t: output transfer with nothing expected: %s",
                                 $realtime,
                                 $sformatf("Y0 %h Cr %h Y1 %h Cb %h last %b",
                                           got.luma_first, got.chroma_red,
                                           got.luma_second, got.chroma_blue,
                                           got.is_last));
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_words.pop_front();
                    if (got.luma_first !== want.luma_first ||
                        got.chroma_red !== want.chroma_red ||
                        got.luma_second !== want.luma_second ||
                        got.chroma_blue !== want.chroma_blue ||
                        got.is_last !== want.is_last) begin
                        if (o_fail_count < MAX_REPORTS)
                            $display("%0t: mismatch exp %s, got %s", $realtime,
                                     $sformatf("Y0 %h Cr %h Y1 %h Cb %h last %b",
                                               want.luma_first, want.chroma_red,
                                               want.luma_second, want.chroma_blue,
                                               want.is_last),
                                     $sformatf("Y0 %h Cr %h Y1 %h Cb %h last %b",
                                               got.luma_first, got.chroma_red,
                                               got.luma_second, got.chroma_blue,
                                               got.is_last));
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                expected_words.push_back(convert_pair(i_s_tdata, i_s_tlast));
            o_pending <= expected_words.size();
        end
    end

endmodule

FILE: tb/sv/tb_rgb_pair_to_ycbcr422.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_pair_to_ycbcr422
// Drives pixel pairs into the RGB to YCbCr 4:2:2 converter: directed corner
// colors first, then random pairs, with random gaps on the input and random
// back-pressure on the output. The checker beside the block does the
// prediction and comparison; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_rgb_pair_to_ycbcr422;

    localparam int RANDOM_PAIRS = 1100;
    localparam int IDLE_PCT     = 28;
    localparam int DRAIN_CYCLES = 10;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // R0, G0, B0, R1, G1, B1 from bit 0 up
    logic        s_axis_tlast;   // pair_is_last
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // Y0, Cr, Y1, Cb from bit 0 up
    logic        m_axis_tlast;   // out_is_last

    int   fail_count;
    int   pending;
    int   idle_pct;
    logic pair_taken;

    rgb_pair_to_ycbcr422 dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    ycc422_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tlast   (s_axis_tlast),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tdata   (m_axis_tdata),
        .i_m_tlast   (m_axis_tlast),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end

    // flag an input transfer so the driver can see it at the next falling edge
    always @(posedge i_clk) begin
        pair_taken <= s_axis_tvalid && s_axis_tready;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end

    // present one pair after a random gap; return at the falling edge after the transfer
    task automatic send_pair(input logic [47:0] pix, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 48'({$urandom, $urandom});
            s_axis_tlast  <= 1'($urandom_range(1));
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tlast  <= last;
        @(negedge i_clk);
        while (!pair_taken)
            @(negedge i_clk);
    endtask

    function automatic logic [47:0] pair_of(logic [23:0] left, logic [23:0] right);
        return {right, left};
    endfunction

    initial begin
        logic [47:0] pix;
        int          wait_cycles;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        idle_pct      = IDLE_PCT;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // corner colors, packed blue:green:red per pixel
        send_pair(pair_of(24'h000000, 24'h000000), 1'b0);
        send_pair(pair_of(24'hFFFFFF, 24'hFFFFFF), 1'b1);
        send_pair(pair_of(24'h0000FF, 24'h0000FF), 1'b0);
        send_pair(pair_of(24'h00FF00, 24'h00FF00), 1'b0);
        send_pair(pair_of(24'hFF0000, 24'hFF0000), 1'b0);
        send_pair(pair_of(24'h000000, 24'hFFFFFF), 1'b0);
        send_pair(pair_of(24'hFFFFFF, 24'h000000), 1'b1);
        // chroma extremes: max Cr is pure red, min Cr is cyan; max Cb is blue, min Cb is yellow
        send_pair(pair_of(24'h0000FF, 24'h00FF00), 1'b0);
        send_pair(pair_of(24'hFF0000, 24'h00FFFF), 1'b0);
        send_pair(pair_of(24'h00FFFF, 24'hFFFF00), 1'b0);
        send_pair(pair_of(24'hFF00FF, 24'hFF00FF), 1'b0);
        send_pair(pair_of(24'hAAAAAA, 24'h555555), 1'b1);
        send_pair(pair_of(24'h555555, 24'hAAAAAA), 1'b0);
        send_pair(pair_of(24'h808080, 24'h7F7F7F), 1'b0);
        send_pair(pair_of(24'h010101, 24'hFEFEFE), 1'b1);

        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            // let the pipeline drain completely once
            if (n == 300) begin
                s_axis_tvalid <= 1'b0;
                @(negedge i_clk);
                while (pending != 0)
                    @(negedge i_clk);
            end
            // long stretch at full rate on both sides
            if (n == 500)
                idle_pct = 0;
            if (n == 750)
                idle_pct = IDLE_PCT;
            pix = 48'({$urandom, $urandom});
            // bias some pairs toward the color extremes
            if ($urandom_range(9) == 0)
                for (int b = 0; b < 6; b++)
                    pix[b*8 +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
            send_pair(pix, ($urandom_range(7) == 0));
        end
        s_axis_tvalid <= 1'b0;

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 1000) begin
            @(negedge i_clk);
            wait_cycles++;
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/rgbycc_pkg.sv
rtl/core/rgb_pair_to_ycbcr422.sv
rtl/core/rgbycc_checker.sv
tb/sv/ycc422_checker.sv
tb/sv/tb_rgb_pair_to_ycbcr422.sv
